/* rtl/core/fixed_point_q24_8_alu_assert.svh */
// Assertion macros for the Q24.8 fixed-point ALU.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef FIXED_POINT_Q24_8_ALU_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_ASSERT_SVH

// Same-cycle implication
`define FPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/fpa_pkg.sv */
// Shared types and constants for the Q24.8 fixed-point ALU.
// No dependencies.
`default_nettype none

package fpa_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 8;
  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    ERR_OK   = 2'd0,
    ERR_DIV0 = 2'd1,
    ERR_OVF  = 2'd2
  } err_e;

  // Input transfer payload
  typedef struct packed {
    op_e                      op;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } in_t;

  // Output transfer payload
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     flag;
    err_e                     error;
  } out_t;

  // Per-stage control carried along the divider chain
  typedef struct packed {
    logic valid;
    logic is_div;  // result comes from the quotient
    logic neg;     // quotient sign
  } ctl_t;

endpackage

`default_nettype wire

/* rtl/core/fixed_point_q24_8_alu.sv */
// Signed fixed-point ALU, WORD_BITS raw words with FRAC_BITS fraction bits
// (Q24.8 by default). Fully pipelined: one transfer in and one transfer out
// per cycle when neither side stalls. Every operation has the same latency
// through two front-end stages (operand capture with the multiplier, then
// result forming), one cell per quotient bit in the divider chain, and the
// output register. The divider chain sets most of that latency. A stall on
// the output holds the whole pipeline.
// Depends on fpa_pkg, fpa_prep, fpa_cell, fpa_post and fixed_point_q24_8_alu_assert.svh.
`default_nettype none
`include "fixed_point_q24_8_alu_assert.svh"

module fixed_point_q24_8_alu #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire fpa_pkg::in_t  in_data_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output fpa_pkg::out_t      out_data_o,
  input  wire logic          out_stall_i
);

  localparam int W  = WORD_BITS;
  localparam int N  = WORD_BITS + FRAC_BITS;
  localparam int NC = N;  // one cell per quotient bit

  // Pipeline advances unless a held result is stalled
  logic en;
  assign in_stall_o = out_valid_o && out_stall_i;
  assign en         = !in_stall_o;

  fpa_pkg::ctl_t ctl [0:NC];
  fpa_pkg::out_t res [0:NC];
  logic [W-1:0]  dvs [0:NC];
  logic [W-1:0]  rem [0:NC];
  logic [N-1:0]  dq  [0:NC];

  assign rem[0] = '0;

  fpa_prep #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .ctl_o      (ctl[0]),
    .res_o      (res[0]),
    .dvs_o      (dvs[0]),
    .dq_o       (dq[0])
  );

  // Divider chain
  for (genvar i = 0; i < NC; i++) begin : g_cell
    fpa_cell #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl[i]),
      .res_i  (res[i]),
      .dvs_i  (dvs[i]),
      .rem_i  (rem[i]),
      .dq_i   (dq[i]),
      .ctl_o  (ctl[i+1]),
      .res_o  (res[i+1]),
      .dvs_o  (dvs[i+1]),
      .rem_o  (rem[i+1]),
      .dq_o   (dq[i+1])
    );
  end

  fpa_post #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .ctl_i       (ctl[NC]),
    .res_i       (res[NC]),
    .dq_i        (dq[NC]),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // Checks
  `FPA_ASSERT_NOW(a_div_rem, ctl[NC].valid && ctl[NC].is_div, rem[NC] < dvs[NC], "remainder not below divisor")
  `FPA_ASSERT_NEXT(a_chain_hold, out_valid_o && out_stall_i, $stable(ctl[NC].valid), "chain moved during stall")
  `FPA_ASSERT_NOW(a_flag_only, out_valid_o && out_data_o.flag, out_data_o.value == '0 && out_data_o.error == fpa_pkg::ERR_OK, "compare result carries value or error")
  `FPA_ASSERT_NOW(a_div0_zero, out_valid_o && out_data_o.error == fpa_pkg::ERR_DIV0, out_data_o.value == '0, "divide by zero with nonzero value")

endmodule

`default_nettype wire

/* rtl/core/fpa_prep.sv */
// Front end: operand capture, multiplier, all non-divide results, divider setup.
// Depends on fpa_pkg.
`default_nettype none

module fpa_prep #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           in_valid_i,
  input  wire fpa_pkg::in_t                   in_data_i,
  output fpa_pkg::ctl_t                       ctl_o,
  output fpa_pkg::out_t                       res_o,
  output logic [WORD_BITS-1:0]                dvs_o,
  output logic [WORD_BITS+FRAC_BITS-1:0]      dq_o
);

  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;
  localparam logic [2*W-1:0] MUL_BIAS = {{(2*W-F){1'b0}}, {F{1'b1}}};
  localparam logic [W-1:0]   INT_BIAS = {{(W-F){1'b0}}, {F{1'b1}}};

  // Stage 1: capture and multiply
  logic                    v1_q;
  fpa_pkg::op_e            op1_q;
  logic signed [W-1:0]     a1_q, b1_q;
  logic signed [2*W-1:0]   prod1_q;
  logic signed [W-1:0]     a_w, b_w;

  assign a_w = in_data_i.a[W-1:0];
  assign b_w = in_data_i.b[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q   <= in_data_i.op;
      a1_q    <= a_w;
      b1_q    <= b_w;
      prod1_q <= (2*W)'(a_w) * (2*W)'(b_w);
    end
  end

  // Multiply: scale down toward zero, check range
  logic signed [2*W-1:0] msum, mex;
  logic signed [W-1:0]   mul_w;
  logic                  mul_ovf;

  assign msum    = prod1_q + (prod1_q[2*W-1] ? MUL_BIAS : '0);
  assign mex     = msum >>> F;
  assign mul_w   = mex[W-1:0];
  assign mul_ovf = !((&mex[2*W-1:W-1]) || !(|mex[2*W-1:W-1]));

  // Integer conversions
  logic signed [W+F-1:0] fex;
  logic signed [W-1:0]   fromi_w, toi_w, tsum;
  logic                  fromi_ovf;

  assign fex       = (W+F)'(a1_q) <<< F;
  assign fromi_w   = fex[W-1:0];
  assign fromi_ovf = !((&fex[W+F-1:W-1]) || !(|fex[W+F-1:W-1]));
  assign tsum      = a1_q + (a1_q[W-1] ? INT_BIAS : '0);
  assign toi_w     = tsum >>> F;

  // Wrapping arithmetic and compares
  logic signed [W-1:0] sum_w, diff_w, inc_w, dec_w;
  logic                lt, eq;

  assign sum_w  = a1_q + b1_q;
  assign diff_w = a1_q - b1_q;
  assign inc_w  = a1_q + W'(1);
  assign dec_w  = a1_q - W'(1);
  assign lt     = a1_q < b1_q;
  assign eq     = a1_q == b1_q;

  // Divider setup: magnitudes and sign
  logic [W-1:0]   mag_a, mag_b;
  logic signed [W-1:0] neg_a, neg_b;
  logic           dzero;

  assign neg_a = -a1_q;
  assign neg_b = -b1_q;
  assign mag_a = a1_q[W-1] ? neg_a : a1_q;
  assign mag_b = b1_q[W-1] ? neg_b : b1_q;
  assign dzero = !(|b1_q);

  fpa_pkg::out_t res_d;
  fpa_pkg::ctl_t ctl_d;

  always_comb begin
    res_d = '0;
    ctl_d = '0;
    ctl_d.valid = v1_q;
    case (op1_q)
      fpa_pkg::OP_ADD: res_d.value = fpa_pkg::DATA_W'(sum_w);
      fpa_pkg::OP_SUB: res_d.value = fpa_pkg::DATA_W'(diff_w);
      fpa_pkg::OP_MUL: begin
        res_d.value = fpa_pkg::DATA_W'(mul_w);
        res_d.error = mul_ovf ? fpa_pkg::ERR_OVF : fpa_pkg::ERR_OK;
      end
      fpa_pkg::OP_DIV: begin
        // zero divisor answers here; otherwise the quotient decides
        res_d.error  = dzero ? fpa_pkg::ERR_DIV0 : fpa_pkg::ERR_OK;
        ctl_d.is_div = !dzero;
        ctl_d.neg    = a1_q[W-1] ^ b1_q[W-1];
      end
      fpa_pkg::OP_GT:  res_d.flag = !lt && !eq;
      fpa_pkg::OP_LT:  res_d.flag = lt;
      fpa_pkg::OP_GE:  res_d.flag = !lt;
      fpa_pkg::OP_LE:  res_d.flag = lt || eq;
      fpa_pkg::OP_EQ:  res_d.flag = eq;
      fpa_pkg::OP_NE:  res_d.flag = !eq;
      fpa_pkg::OP_MIN: res_d.value = fpa_pkg::DATA_W'(lt ? a1_q : b1_q);
      fpa_pkg::OP_MAX: res_d.value = fpa_pkg::DATA_W'(lt ? b1_q : a1_q);
      fpa_pkg::OP_INC: res_d.value = fpa_pkg::DATA_W'(inc_w);
      fpa_pkg::OP_DEC: res_d.value = fpa_pkg::DATA_W'(dec_w);
      fpa_pkg::OP_FROM_INT: begin
        res_d.value = fpa_pkg::DATA_W'(fromi_w);
        res_d.error = fromi_ovf ? fpa_pkg::ERR_OVF : fpa_pkg::ERR_OK;
      end
      fpa_pkg::OP_TO_INT: res_d.value = fpa_pkg::DATA_W'(toi_w);
      default: res_d = '0;
    endcase
  end

  // Stage 2 registers
  fpa_pkg::ctl_t ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_d;
      dvs_o <= mag_b;
      dq_o  <= {mag_a, {F{1'b0}}};
    end
  end

  assign ctl_o = ctl_q;

endmodule

`default_nettype wire

/* rtl/core/fpa_cell.sv */
// One divider cell: produces one quotient bit and forwards everything else.
// Depends on fpa_pkg.
`default_nettype none

module fpa_cell #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire fpa_pkg::ctl_t                    ctl_i,
  input  wire fpa_pkg::out_t                    res_i,
  input  wire logic [WORD_BITS-1:0]             dvs_i,
  input  wire logic [WORD_BITS-1:0]             rem_i,
  input  wire logic [WORD_BITS+FRAC_BITS-1:0]   dq_i,
  output fpa_pkg::ctl_t                         ctl_o,
  output fpa_pkg::out_t                         res_o,
  output logic [WORD_BITS-1:0]                  dvs_o,
  output logic [WORD_BITS-1:0]                  rem_o,
  output logic [WORD_BITS+FRAC_BITS-1:0]        dq_o
);

  localparam int W = WORD_BITS;
  localparam int N = WORD_BITS + FRAC_BITS;

  // Restoring step: shift in next dividend bit, trial subtract
  logic [W:0]   rem_sh, rem_sub;
  logic         take;
  logic [W-1:0] rem_d;
  logic [N-1:0] dq_d;

  assign rem_sh  = {rem_i, dq_i[N-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_i};
  assign take    = rem_sh >= {1'b0, dvs_i};
  assign rem_d   = take ? rem_sub[W-1:0] : rem_sh[W-1:0];
  assign dq_d    = {dq_i[N-2:0], take};

  fpa_pkg::ctl_t ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_i;
      dvs_o <= dvs_i;
      rem_o <= rem_d;
      dq_o  <= dq_d;
    end
  end

  assign ctl_o = ctl_q;

endmodule

`default_nettype wire

/* rtl/core/fpa_post.sv */
// Output stage: signs and range-checks the quotient, holds the result transfer.
// Depends on fpa_pkg.
`default_nettype none

module fpa_post #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire fpa_pkg::ctl_t                    ctl_i,
  input  wire fpa_pkg::out_t                    res_i,
  input  wire logic [WORD_BITS+FRAC_BITS-1:0]   dq_i,
  output logic                                  out_valid_o,
  output fpa_pkg::out_t                         out_data_o
);

  localparam int W = WORD_BITS;
  localparam int N = WORD_BITS + FRAC_BITS;

  // Quotient magnitude to signed word; low bits of the exact result
  logic [W-1:0]        q_w;
  logic signed [W-1:0] q_neg, dv_w;
  logic                fits_pos, fits_neg, fits;

  assign q_w      = dq_i[W-1:0];
  assign q_neg    = -q_w;
  assign dv_w     = ctl_i.neg ? q_neg : q_w;
  assign fits_pos = !(|dq_i[N-1:W-1]);
  assign fits_neg = !(|dq_i[N-1:W]) && (!dq_i[W-1] || !(|dq_i[W-2:0]));
  assign fits     = ctl_i.neg ? fits_neg : fits_pos;

  fpa_pkg::out_t out_d;

  always_comb begin
    out_d = res_i;
    if (ctl_i.is_div) begin
      out_d.value = fpa_pkg::DATA_W'(dv_w);
      out_d.flag  = 1'b0;
      out_d.error = fits ? fpa_pkg::ERR_OK : fpa_pkg::ERR_OVF;
    end
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && ctl_i.valid) begin
      out_data_o <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* verif/fpa_checker.sv */
// Result checker for the Q24.8 fixed-point ALU: watches both channels, predicts
// each result from the accepted operation and compares in arrival order.
// Depends on fpa_pkg.
`default_nettype none

module fpa_checker
  import fpa_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire in_t  in_data_i,
  input  wire logic in_stall_i,
  input  wire logic out_valid_i,
  input  wire out_t out_data_i,
  input  wire logic out_stall_i,
  output int        err_cnt_o,
  output int        pending_o,
  output int        checked_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [63:0] wide_t;

  localparam wide_t SCALE    = wide_t'(1) <<< FRAC_BITS_DEF;
  localparam wide_t WORD_MAX = (wide_t'(1) <<< (WORD_BITS_DEF - 1)) - 1;
  localparam wide_t WORD_MIN = -(wide_t'(1) <<< (WORD_BITS_DEF - 1));

  out_t alu_results_q[$];

  // Exact arithmetic at 64 bits, then cut back to the word; signed division
  // truncates toward zero, as the block's multiply, divide and to_int do.
  function automatic out_t alu_result(in_t t);
    wide_t sa;
    wide_t sb;
    wide_t full;
    out_t  r;
    sa      = $signed(t.a);
    sb      = $signed(t.b);
    full    = '0;
    r.value = '0;
    r.flag  = 1'b0;
    r.error = ERR_OK;
    case (t.op)
      OP_ADD: begin
        full    = sa + sb;
        r.value = full[DATA_W-1:0];
      end
      OP_SUB: begin
        full    = sa - sb;
        r.value = full[DATA_W-1:0];
      end
      OP_MUL: begin
        full    = (sa * sb) / SCALE;
        r.value = full[DATA_W-1:0];
        if (full > WORD_MAX || full < WORD_MIN) r.error = ERR_OVF;
      end
      OP_DIV: begin
        if (sb == 0) begin
          r.error = ERR_DIV0;
        end else begin
          full    = (sa * SCALE) / sb;
          r.value = full[DATA_W-1:0];
          if (full > WORD_MAX || full < WORD_MIN) r.error = ERR_OVF;
        end
      end
      OP_GT: r.flag = (sa > sb);
      OP_LT: r.flag = (sa < sb);
      OP_GE: r.flag = (sa >= sb);
      OP_LE: r.flag = (sa <= sb);
      OP_EQ: r.flag = (sa == sb);
      OP_NE: r.flag = (sa != sb);
      OP_MIN: r.value = (sa < sb) ? t.a : t.b;
      OP_MAX: r.value = (sa < sb) ? t.b : t.a;
      OP_INC: begin
        full    = sa + 1;
        r.value = full[DATA_W-1:0];
      end
      OP_DEC: begin
        full    = sa - 1;
        r.value = full[DATA_W-1:0];
      end
      OP_FROM_INT: begin
        full    = sa * SCALE;
        r.value = full[DATA_W-1:0];
        if (full > WORD_MAX || full < WORD_MIN) r.error = ERR_OVF;
      end
      default: begin
        // to_int
        full    = sa / SCALE;
        r.value = full[DATA_W-1:0];
      end
    endcase
    return r;
  endfunction

  // Queue expectations on input transfers, compare on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      alu_results_q.delete();
      err_cnt_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) alu_results_q.push_back(alu_result(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        checked_o <= checked_o + 1;
        if (alu_results_q.size() == 0) begin
          err_cnt_o <= err_cnt_o + 1;
          $display("%0t: result with nothing expected: value=%h flag=%b error=%0d",
                   $realtime, out_data_i.value, out_data_i.flag, out_data_i.error);
        end else begin
          want = alu_results_q.pop_front();
          if (want.value !== out_data_i.value || want.flag !== out_data_i.flag ||
              want.error !== out_data_i.error) begin
            err_cnt_o <= err_cnt_o + 1;
            $display({"%0t: mismatch: expected value=%h flag=%b error=%0d, ",
                      "got value=%h flag=%b error=%0d"},
                     $realtime, want.value, want.flag, want.error,
                     out_data_i.value, out_data_i.flag, out_data_i.error);
          end
        end
      end
      pending_o <= alu_results_q.size();
    end
  end

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Top of the Q24.8 ALU testbench: clock, reset, operation stimulus, output
// backpressure and the verdict. Depends on fpa_pkg, fpa_checker and the ALU.
`default_nettype none

module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import fpa_pkg::*;

  localparam int N_RANDOM    = 1760;
  localparam int N_QUIET     = 200;
  localparam int N_HOLD_OPS  = 80;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_WAIT  = 60;
  localparam int CYCLE_LIMIT = 500000;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;

  int err_cnt;
  int pending;
  int checked;
  int n_sent    = 0;
  bit quiet     = 1'b0;
  bit hold_req  = 1'b0;

  fixed_point_q24_8_alu dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  fpa_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_i  (in_stall_o),
    .out_valid_i (out_valid_o),
    .out_data_i  (out_data_o),
    .out_stall_i (out_stall_i),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // 10 ns clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, pending);
    $display("Simulation FAILED");
    $finish;
  end

  // Output backpressure: random stall/run bursts, a long hold on request,
  // no stalls once the quiet phase starts
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        hold_req = 1'b0;
        n = HOLD_CYCLES;
      end else if (quiet || $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b0;
        n = quiet ? 1 : $urandom_range(1, 18);
      end else begin
        out_stall_i <= 1'b1;
        n = $urandom_range(1, 18);
      end
      repeat (n) @(negedge clk_i);
    end
  end

  function automatic in_t make_op(op_e op, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    in_t t;
    t.op = op;
    t.a  = a;
    t.b  = b;
    return t;
  endfunction

  // Operand mix: corner words, small and mid-range values, full-range words
  function automatic logic [DATA_W-1:0] rand_operand();
    logic [DATA_W-1:0] w;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0:       w = 32'h8000_0000;
          1:       w = 32'h7fff_ffff;
          2:       w = 32'h0000_0000;
          3:       w = 32'hffff_ffff;
          4:       w = 32'h0000_0001;
          5:       w = 32'h0000_0100;
          default: w = 32'hffff_ff00;
        endcase
      end
      1, 2, 3: w = $urandom_range(0, 8191) - 4096;
      4, 5:    w = $urandom_range(0, 2097151) - 1048576;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_op(in_t t);
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (in_stall_o);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic idle_input(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Stop offering until every queued result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // Stimulus and verdict
  initial begin
    in_t t;
    int  r;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed corners: wraps, overflows, divide by zero, truncation, ties
    send_op(make_op(OP_ADD,      32'h7fff_ffff, 32'h0000_0001));
    send_op(make_op(OP_ADD,      32'hffff_ffff, 32'hffff_ffff));
    send_op(make_op(OP_SUB,      32'h8000_0000, 32'h0000_0001));
    send_op(make_op(OP_MUL,      32'h7fff_ffff, 32'h7fff_ffff));
    send_op(make_op(OP_MUL,      32'h8000_0000, 32'h8000_0000));
    send_op(make_op(OP_MUL,      32'hffff_ffff, 32'h0000_0001));
    send_op(make_op(OP_DIV,      32'h0000_0064, 32'h0000_0000));
    send_op(make_op(OP_DIV,      32'h8000_0000, 32'h0000_0001));
    send_op(make_op(OP_DIV,      32'h8000_0000, 32'hffff_ffff));
    send_op(make_op(OP_DIV,      32'hffff_ffff, 32'h0000_0003));
    send_op(make_op(OP_GT,       32'h8000_0000, 32'h7fff_ffff));
    send_op(make_op(OP_LT,       32'h8000_0000, 32'h7fff_ffff));
    send_op(make_op(OP_GE,       32'h0000_0005, 32'h0000_0005));
    send_op(make_op(OP_LE,       32'hffff_ffff, 32'h0000_0000));
    send_op(make_op(OP_EQ,       32'h7fff_ffff, 32'h7fff_ffff));
    send_op(make_op(OP_NE,       32'h0000_0000, 32'h0000_0000));
    send_op(make_op(OP_MIN,      32'h8000_0000, 32'h7fff_ffff));
    send_op(make_op(OP_MAX,      32'hffff_fffc, 32'hffff_fffc));
    send_op(make_op(OP_INC,      32'h7fff_ffff, 32'h0000_0000));
    send_op(make_op(OP_DEC,      32'h8000_0000, 32'hffff_ffff));
    send_op(make_op(OP_FROM_INT, 32'h0080_0000, 32'h0000_0000));
    send_op(make_op(OP_FROM_INT, 32'hff80_0000, 32'h0000_0000));
    send_op(make_op(OP_TO_INT,   32'hffff_ffff, 32'h0000_0000));
    send_op(make_op(OP_TO_INT,   32'h8000_0000, 32'h0000_0000));
    drain_results();

    // Long output hold while operations keep coming, to back up the pipeline
    hold_req = 1'b1;
    for (int i = 0; i < N_HOLD_OPS; i++)
      send_op(make_op(op_e'($urandom_range(0, 15)), rand_operand(), rand_operand()));

    // Random operations; pause for a full drain halfway, no idling at the end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) drain_results();
      if (i == N_RANDOM - N_QUIET) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) idle_input($urandom_range(1, 18));
      t.op = op_e'($urandom_range(0, 15));
      t.a  = rand_operand();
      r    = $urandom_range(0, 15);
      if (r == 0)      t.b = '0;
      else if (r == 1) t.b = t.a;
      else             t.b = rand_operand();
      send_op(t);
    end

    // Wait out the results, then the pipeline depth for any stray output
    drain_results();
    repeat (DRAIN_WAIT) @(negedge clk_i);

    $display("Sent %0d operations (24 directed corners, all 16 opcodes), checked %0d results",
             n_sent, checked);
    $display("with random input gaps, output stalls, a %0d-cycle output hold and a full drain",
             HOLD_CYCLES);
    if (err_cnt == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl/core
rtl/core/fpa_pkg.sv
rtl/core/fpa_prep.sv
rtl/core/fpa_cell.sv
rtl/core/fpa_post.sv
rtl/core/fixed_point_q24_8_alu.sv
verif/fpa_checker.sv
verif/tb_top.sv
